// ===== src/sliding_window_median_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window median filter
// Shared wrappers that clock every check on clk and report through $error.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH

// Check that is switched off while reset is held.
`define SWMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also runs during reset.
`define SWMF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/swmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Median filter package
// Sizes, register indexes and the link types between neighboring cells.
// ----------------------------------------------------------------------------
package swmf_pkg;

  // Largest window and sample width.
  localparam int MAX_WINDOW  = 16;
  localparam int SAMPLE_BITS = 16;

  // Derived widths: cell index / age, and a count that can hold MAX_WINDOW.
  localparam int AGE_BITS = $clog2(MAX_WINDOW);
  localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);

  // Width of the window length register and of the configuration data.
  localparam int WL_BITS  = 5;
  localparam int CFG_BITS = 5;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_FILTER_ENABLE = 1'b0,
    REG_WINDOW_LENGTH = 1'b1
  } swmf_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [AGE_BITS-1:0]           age_t;

  // Common control broadcast to every cell.
  typedef struct packed {
    logic    load;    // a filtered transaction updates the chain
    logic    evict;   // the oldest sample leaves the chain
    age_t    oldest;  // age of the oldest held sample
    sample_t sample;  // new sample to insert
  } swmf_ctl_t;

  // Data handed from a cell to its right-hand neighbor.
  typedef struct packed {
    logic    shift;   // a sample at or left of this cell is evicted
    logic    gt;      // this cell's compacted value lies above the new sample
    sample_t value;   // compacted value
    age_t    age;     // compacted age
  } swmf_link_t;

  // Data handed from a cell to its left-hand neighbor.
  typedef struct packed {
    sample_t value;
    age_t    age;
  } swmf_tap_t;

endpackage

// ===== src/sliding_window_median_filter.sv =====
// ----------------------------------------------------------------------------
// Sliding window median filter
// Running median over the most recent samples, held in a sorted cell chain.
// ----------------------------------------------------------------------------
// One sample in, one filtered sample out. The samples are kept sorted in a
// chain of cells; each accepted sample evicts the oldest one (once the window
// is full) and is inserted in place, so the block takes one transaction per
// clock while the input is not stalled. The chain and the select stage are
// registered together, then the median select feeds the output register.
// Back-pressure on the output stalls the input only when both the select
// stage and the output register are full. While filling, the element at
// index count/2 of the sorted samples is returned (upper median for even
// counts). Bypass (enable clear or window length 0 or 1) returns the input
// unchanged and leaves the held samples alone. Window lengths above 16 act as
// 16. The user writes configuration only while idle; the block does not check.
// ----------------------------------------------------------------------------
`include "sliding_window_median_filter_assert.svh"

module sliding_window_median_filter (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [0:0]                     cfg_index,
  input  logic [swmf_pkg::CFG_BITS-1:0]  cfg_data,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic signed [swmf_pkg::SAMPLE_BITS-1:0] s_axis_tdata, // [15:0] sample_in
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic signed [swmf_pkg::SAMPLE_BITS-1:0] m_axis_tdata  // [15:0] sample_out
);

  localparam int N = swmf_pkg::MAX_WINDOW;

  // Configuration registers
  logic                          filter_enable;
  logic [swmf_pkg::WL_BITS-1:0]  window_length;

  // Chain bookkeeping
  logic [swmf_pkg::CNT_BITS-1:0] fill_count;
  logic [swmf_pkg::CNT_BITS-1:0] fill_count_next;
  logic [swmf_pkg::CNT_BITS-1:0] count_post;
  logic [swmf_pkg::CNT_BITS-1:0] win;
  logic                          bypass;
  logic                          evict;
  logic                          in_fire;
  swmf_pkg::swmf_ctl_t           ctl;

  // Select stage
  logic                          mid_valid;
  logic                          mid_bypass;
  swmf_pkg::sample_t             mid_sample;
  swmf_pkg::age_t                mid_idx;
  logic                          mid_move;

  // Cell links
  swmf_pkg::swmf_link_t          link [N+1];
  swmf_pkg::swmf_tap_t           tap  [N+1];
  swmf_pkg::sample_t             cell_value [N];

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b1;
      window_length <= swmf_pkg::WL_BITS'(5);
    end else if (cfg_valid) begin
      case (swmf_pkg::swmf_reg_t'(cfg_index))
        swmf_pkg::REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        swmf_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data[swmf_pkg::WL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: input stalls only when the select stage cannot drain.
  assign mid_move      = mid_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !mid_valid || !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Window decode and fill count update.
  always_comb begin
    if (32'(window_length) > 32'(N)) begin
      win = swmf_pkg::CNT_BITS'(N);
    end else begin
      win = swmf_pkg::CNT_BITS'(window_length);
    end
    bypass = !filter_enable || (win <= swmf_pkg::CNT_BITS'(1));
    evict  = (fill_count >= win);
    if (evict) begin
      count_post      = fill_count - swmf_pkg::CNT_BITS'(1);
      fill_count_next = fill_count;
    end else begin
      count_post      = fill_count;
      fill_count_next = fill_count + swmf_pkg::CNT_BITS'(1);
    end
    ctl.load   = in_fire && !bypass;
    ctl.evict  = evict;
    ctl.oldest = swmf_pkg::AGE_BITS'(fill_count - swmf_pkg::CNT_BITS'(1));
    ctl.sample = s_axis_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (ctl.load) begin
      fill_count <= fill_count_next;
    end
  end

  // Chain ends: nothing enters from the left, the last cell sees itself.
  assign link[0] = '{shift: 1'b0, gt: 1'b0, value: '0, age: '0};
  assign tap[N]  = tap[N-1];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic live;
    logic live_post;
    assign live      = (swmf_pkg::CNT_BITS'(i) < fill_count);
    assign live_post = (swmf_pkg::CNT_BITS'(i) < count_post);
    swmf_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .live      (live),
      .live_post (live_post),
      .left_in   (link[i]),
      .right_in  (tap[i+1]),
      .right_out (link[i+1]),
      .left_out  (tap[i]),
      .value     (cell_value[i])
    );
  end

  // Select stage: remembers which cell holds the median.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_fire) begin
      mid_valid <= 1'b1;
    end else if (mid_move) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mid_bypass <= bypass;
      mid_sample <= s_axis_tdata;
      mid_idx    <= swmf_pkg::AGE_BITS'(fill_count_next >> 1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (mid_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_move) begin
      m_axis_tdata <= mid_bypass ? mid_sample : cell_value[mid_idx];
    end
  end

  // Checks
  `SWMF_ASSERT(a_count_bound, fill_count <= swmf_pkg::CNT_BITS'(N), "fill count above window maximum")
  `SWMF_ASSERT(a_fill_grows, (ctl.load && !evict) |=> (fill_count == $past(fill_count) + swmf_pkg::CNT_BITS'(1)), "fill count did not grow while filling")
  `SWMF_ASSERT(a_bypass_keeps, (in_fire && bypass) |=> $stable(fill_count), "bypass transaction changed the held samples")
  `SWMF_ASSERT(a_median_held, (mid_valid && !mid_bypass) |-> (swmf_pkg::CNT_BITS'(mid_idx) < fill_count), "median index outside held samples")
  `SWMF_ASSERT_ALWAYS(a_reset_idle, rst |=> (!m_axis_tvalid && !mid_valid), "output pending after reset")

endmodule

// ===== src/swmf_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted chain cell
// Holds one sample and its age. Cells keep ascending order from left to
// right; a transaction inserts the new sample, evicting the oldest when full.
// ----------------------------------------------------------------------------
module swmf_cell (
  input  logic                clk,
  input  swmf_pkg::swmf_ctl_t ctl,
  input  logic                live,       // cell holds a sample now
  input  logic                live_post,  // cell holds a sample after eviction
  input  swmf_pkg::swmf_link_t left_in,
  input  swmf_pkg::swmf_tap_t  right_in,
  output swmf_pkg::swmf_link_t right_out,
  output swmf_pkg::swmf_tap_t  left_out,
  output swmf_pkg::sample_t    value
);

  swmf_pkg::age_t    age;
  swmf_pkg::sample_t value_next;
  swmf_pkg::age_t    age_next;
  logic              hit;
  logic              shift;
  swmf_pkg::sample_t cval;
  swmf_pkg::age_t    cage;
  logic              gt;

  // Eviction: this cell or one to its left drops out, so take the right value.
  always_comb begin
    hit   = ctl.evict && live && (age == ctl.oldest);
    shift = left_in.shift || hit;
    cval  = shift ? right_in.value : value;
    cage  = shift ? right_in.age : age;
    gt    = !live_post || (cval > ctl.sample);
  end

  // Insertion: cells above the new sample move one place to the right.
  always_comb begin
    if (gt) begin
      if (left_in.gt) begin
        value_next = left_in.value;
        age_next   = left_in.age + swmf_pkg::age_t'(1);
      end else begin
        value_next = ctl.sample;
        age_next   = '0;
      end
    end else begin
      value_next = cval;
      age_next   = cage + swmf_pkg::age_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= value_next;
      age   <= age_next;
    end
  end

  assign right_out = '{shift: shift, gt: gt, value: cval, age: cage};
  assign left_out  = '{value: value, age: age};

endmodule
